FILE: design/kps_pkg.sv
// Shared types, constants and key lookup for the keypad scanner.
package kps_pkg;

	localparam logic [3:0]  NO_ROW       = 4'hf;
	localparam logic [15:0] SETTLE_RESET = 16'h0014;

	// Scan sequencer phase, one-hot
	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,
		PH_MID    = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_AFTER  = 4'b1000
	} phase_t;

	// One result beat
	typedef struct packed {
		logic [3:0]  row_drive;
		logic        scan_done;
		logic [15:0] key_mask;
		logic [6:0]  key_char;
		logic        key_valid;
	} res_t;

	// Active-low drive pattern for one row
	function automatic logic [3:0] row_pattern(input logic [1:0] row);
		row_pattern = 4'b1111 ^ (4'b0001 << row);
	endfunction

	// Fixed key legend, indexed by mask bit
	function automatic logic [6:0] key_code(input logic [3:0] idx);
		case (idx)
			4'd0:    key_code = 7'h2a; // '*'
			4'd1:    key_code = 7'h30; // '0'
			4'd2:    key_code = 7'h23; // '#'
			4'd3:    key_code = 7'h44; // 'D'
			4'd4:    key_code = 7'h37; // '7'
			4'd5:    key_code = 7'h38; // '8'
			4'd6:    key_code = 7'h39; // '9'
			4'd7:    key_code = 7'h43; // 'C'
			4'd8:    key_code = 7'h34; // '4'
			4'd9:    key_code = 7'h35; // '5'
			4'd10:   key_code = 7'h36; // '6'
			4'd11:   key_code = 7'h42; // 'B'
			4'd12:   key_code = 7'h31; // '1'
			4'd13:   key_code = 7'h32; // '2'
			4'd14:   key_code = 7'h33; // '3'
			4'd15:   key_code = 7'h41; // 'A'
			default: key_code = 7'h00;
		endcase
	endfunction

	// Character of the lowest pressed key, zero when none
	function automatic logic [6:0] lowest_key(input logic [15:0] mask);
		logic [15:0] lsb;
		logic [6:0]  acc;
		lsb = mask & (~mask + 16'd1);
		acc = 7'h00;
		for (int i = 0; i < 16; i++) begin
			acc = acc | ({7{lsb[i]}} & key_code(4'(i)));
		end
		lowest_key = acc;
	endfunction

endpackage

FILE: design/kps_if.sv
// Valid/ready channel interfaces for column samples and scan results.
interface kps_col_if;
	logic       valid;
	logic       ready;
	logic [3:0] column_lines;

	modport source (output valid, output column_lines, input ready);
	modport sink (input valid, input column_lines, output ready);
endinterface

interface kps_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row_drive;
	logic        scan_done;
	logic [15:0] key_mask;
	logic [6:0]  key_char;
	logic        key_valid;

	modport source (output valid, output row_drive, output scan_done, output key_mask,
		output key_char, output key_valid, input ready);
	modport sink (input valid, input row_drive, input scan_done, input key_mask,
		input key_char, input key_valid, output ready);
endinterface

FILE: design/kps_core.sv
// Scan sequencer: row stepping, mask gathering, debounce wait and key lookup.
module kps_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              settle_we,
	input  logic [15:0]       settle_data,
	input  logic              take,
	input  logic [3:0]        column_lines,
	output kps_pkg::res_t     res
);

	kps_pkg::phase_t phase_q, phase_d;
	logic [1:0]  row_q, row_d;
	logic [15:0] first_q, first_d;
	logic [15:0] gather_q, gather_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] settle_q;
	logic [15:0] gathered;
	logic [15:0] pressed;

	// Hold the settle time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= kps_pkg::SETTLE_RESET;
		end else if (settle_we) begin
			settle_q <= settle_data;
		end
	end

	// Fold this beat's columns into the mask of the scan in progress
	assign gathered = gather_q | ({12'h000, ~column_lines} << {row_q, 2'b00});
	assign pressed  = first_q & gathered;

	// Next state and result for one beat
	always_comb begin
		phase_d  = phase_q;
		row_d    = row_q;
		first_d  = first_q;
		gather_d = gather_q;
		wait_d   = wait_q;
		res      = '0;
		res.row_drive = kps_pkg::NO_ROW;
		case (phase_q)
			kps_pkg::PH_FIRST, kps_pkg::PH_SECOND: begin
				if (row_q == 2'd3) begin
					if (phase_q == kps_pkg::PH_FIRST) begin
						first_d = gathered;
						phase_d = kps_pkg::PH_MID;
					end else begin
						res.scan_done = 1'b1;
						res.key_mask  = pressed;
						res.key_char  = kps_pkg::lowest_key(pressed);
						res.key_valid = (res.key_char != 7'h00);
						phase_d = kps_pkg::PH_AFTER;
					end
					gather_d = '0;
					row_d    = 2'd0;
					wait_d   = settle_q;
				end else begin
					gather_d      = gathered;
					row_d         = row_q + 2'd1;
					res.row_drive = kps_pkg::row_pattern(row_q + 2'd1);
				end
			end
			kps_pkg::PH_MID, kps_pkg::PH_AFTER: begin
				if (wait_q <= 16'd1) begin
					wait_d   = '0;
					phase_d  = (phase_q == kps_pkg::PH_MID) ? kps_pkg::PH_SECOND
						: kps_pkg::PH_FIRST;
					row_d    = 2'd0;
					gather_d = '0;
					res.row_drive = kps_pkg::row_pattern(2'd0);
				end else begin
					wait_d = wait_q - 16'd1;
				end
			end
			default: begin
				phase_d  = kps_pkg::PH_FIRST;
				row_d    = 2'd0;
				gather_d = '0;
				wait_d   = '0;
			end
		endcase
	end

	// Advance the sequencer on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= kps_pkg::PH_FIRST;
			row_q    <= 2'd0;
			first_q  <= '0;
			gather_q <= '0;
			wait_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			row_q    <= row_d;
			first_q  <= first_d;
			gather_q <= gather_d;
			wait_q   <= wait_d;
		end
	end

`ifndef SYNTHESIS
	a_done_enters_after: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.scan_done) |=> (phase_q == kps_pkg::PH_AFTER))
		else $error("completed scan did not enter the after wait");
	a_valid_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.key_valid |-> (res.scan_done && phase_q == kps_pkg::PH_SECOND && row_q == 2'd3))
		else $error("key_valid outside the end of a second scan");
	a_wait_gather_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == kps_pkg::PH_MID || phase_q == kps_pkg::PH_AFTER)
		|-> (gather_q == 16'h0000 && row_q == 2'd0))
		else $error("gather state not cleared during a wait");
	a_wait_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(take && wait_d > 16'd0) |-> (res.row_drive == kps_pkg::NO_ROW))
		else $error("row driven while a wait is pending");
`endif

endmodule

FILE: design/kps_out_reg.sv
// Result register between the sequencer and the result channel.
module kps_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  kps_pkg::res_t res,
	output logic          free,
	kps_res_if.source     result
);

	logic          valid_q;
	kps_pkg::res_t data_q;

	// Accept a new beat when empty or when the held beat leaves
	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Capture the payload; hold it while stalled
	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

	assign result.valid     = valid_q;
	assign result.row_drive = data_q.row_drive;
	assign result.scan_done = data_q.scan_done;
	assign result.key_mask  = data_q.key_mask;
	assign result.key_char  = data_q.key_char;
	assign result.key_valid = data_q.key_valid;

endmodule

FILE: design/matrix_keypad_scanner.sv
// Top level of the 4x4 keypad scanner with two-scan debounce.
//
//  channel   dir  handshake     payload
//  columns   in   valid/ready   column_lines[3:0]
//  result    out  valid/ready   row_drive, scan_done, key_mask, key_char, key_valid
//  settle    in   settle_we     settle_data[15:0]
//
// Each column beat yields one result beat in the next cycle; one beat a cycle sustained while result is ready.
// The result register is the one register stage between the column and result channels.
// A stalled result holds in the result register; columns are taken only when it frees.
// Reset clears the sequencer to the first scan, row 0, and settle time to 20.
module matrix_keypad_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        settle_we,
	input  logic [15:0] settle_data,
	kps_col_if.sink     columns,
	kps_res_if.source   result
);

	logic          free;
	logic          take;
	kps_pkg::res_t res;

	assign columns.ready = free;
	assign take          = columns.valid && free;

	kps_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.settle_we    (settle_we),
		.settle_data  (settle_data),
		.take         (take),
		.column_lines (columns.column_lines),
		.res          (res)
	);

	kps_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.res    (res),
		.free   (free),
		.result (result)
	);

endmodule

FILE: verif/matrix_keypad_scanner_tb.sv
// Self-checking testbench for the 4x4 keypad scanner: predicted result beats against the DUT.
module matrix_keypad_scanner_tb;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          SEG_ITEMS   = 120;
	localparam logic [15:0] ONE_KEY     = 16'h0001;
	localparam logic [15:0] ALL_KEYS    = 16'hffff;
	localparam logic [3:0]  ALL_OPEN    = 4'hf;

	// Key legend by mask bit, row-major
	localparam logic [6:0] KEY_LEGEND [16] = '{
		7'h2a, 7'h30, 7'h23, 7'h44, 7'h37, 7'h38, 7'h39, 7'h43,
		7'h34, 7'h35, 7'h36, 7'h42, 7'h31, 7'h32, 7'h33, 7'h41
	};

	// Three debounce rounds at the shortest settle: all keys, top key only, bounce
	localparam logic [3:0] DIRECTED [30] = '{
		4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hf,
		4'hf, 4'hf, 4'hf, 4'h7, 4'hf, 4'hf, 4'hf, 4'hf, 4'h7, 4'h0,
		4'hf, 4'hf, 4'hf, 4'hf, 4'h5, 4'h0, 4'h0, 4'h0, 4'h0, 4'ha
	};

	// Sequencer mirror and queue of awaited result beats
	class keypad_scoreboard;
		logic [15:0]     settle;
		kps_pkg::phase_t phase;
		logic [1:0]      row;
		logic [15:0]     first_mask;
		logic [15:0]     gather_mask;
		logic [15:0]     wait_cnt;
		logic [15:0]     pressed_mask;
		kps_pkg::res_t   awaited_beats [$];
		int              mismatches;

		function new();
			settle       = kps_pkg::SETTLE_RESET;
			phase        = kps_pkg::PH_FIRST;
			row          = 2'd0;
			first_mask   = '0;
			gather_mask  = '0;
			wait_cnt     = '0;
			pressed_mask = '0;
			mismatches   = 0;
		endfunction

		function int pending();
			return awaited_beats.size();
		endfunction

		function logic [6:0] lowest_char(logic [15:0] mask);
			for (int i = 0; i < 16; i++) begin
				if (mask[i])
					return KEY_LEGEND[i];
			end
			return 7'h00;
		endfunction

		// Advance the mirror by one column beat and queue its result
		function void take_columns(logic [3:0] cols);
			kps_pkg::res_t r;
			r           = '0;
			r.row_drive = kps_pkg::NO_ROW;
			if (phase == kps_pkg::PH_FIRST || phase == kps_pkg::PH_SECOND) begin
				gather_mask = gather_mask | (16'(~cols & 4'hf) << (4 * row));
				if (row == 2'd3) begin
					if (phase == kps_pkg::PH_FIRST) begin
						first_mask = gather_mask;
						phase      = kps_pkg::PH_MID;
					end else begin
						pressed_mask = first_mask & gather_mask;
						r.scan_done  = 1'b1;
						r.key_mask   = pressed_mask;
						r.key_char   = lowest_char(pressed_mask);
						phase        = kps_pkg::PH_AFTER;
					end
					gather_mask = '0;
					row         = 2'd0;
					wait_cnt    = settle;
				end else begin
					row         = row + 2'd1;
					r.row_drive = 4'hf ^ (4'b0001 << row);
				end
			end else begin
				if (wait_cnt <= 16'd1) begin
					wait_cnt    = '0;
					phase       = (phase == kps_pkg::PH_MID) ? kps_pkg::PH_SECOND
						: kps_pkg::PH_FIRST;
					row         = 2'd0;
					gather_mask = '0;
					r.row_drive = 4'hf ^ 4'b0001;
				end else begin
					wait_cnt = wait_cnt - 16'd1;
				end
			end
			r.key_valid = r.scan_done && (r.key_char != 7'h00);
			awaited_beats.push_back(r);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %h, got %h", field, want, got);
			end
		endfunction

		// Match one result beat against the oldest prediction
		function void check_result(kps_pkg::res_t got);
			kps_pkg::res_t want;
			if (awaited_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing awaited: got %h", got);
				return;
			end
			want = awaited_beats.pop_front();
			compare("row_drive", 16'(want.row_drive), 16'(got.row_drive));
			compare("scan_done", 16'(want.scan_done), 16'(got.scan_done));
			compare("key_mask", want.key_mask, got.key_mask);
			compare("key_char", 16'(want.key_char), 16'(got.key_char));
			compare("key_valid", 16'(want.key_valid), 16'(got.key_valid));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        settle_we;
	logic [15:0] settle_data;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_req;
	int          cycles;
	logic [15:0] keys_held;

	keypad_scoreboard sb;

	kps_col_if col_bus ();
	kps_res_if res_bus ();

	matrix_keypad_scanner u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.settle_we   (settle_we),
		.settle_data (settle_data),
		.columns     (col_bus),
		.result      (res_bus)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Abort on a hung run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Drive result ready: random stalls, or a long hold-off on request
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_req = 0;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					res_bus.ready <= 1'b0;
					@(negedge clk);
				end
			end else begin
				res_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Check every result beat taken
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready)
			sb.check_result({res_bus.row_drive, res_bus.scan_done, res_bus.key_mask,
				res_bus.key_char, res_bus.key_valid});
	end

	// Offer one column beat, idling first at random, and note it once taken
	task automatic send_columns(input logic [3:0] cols);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			col_bus.valid <= 1'b0;
			@(negedge clk);
		end
		col_bus.valid        <= 1'b1;
		col_bus.column_lines <= cols;
		do
			@(posedge clk);
		while (!col_bus.ready);
		sb.take_columns(cols);
	endtask

	// Drop valid and hold off until every awaited beat has come
	task automatic drain();
		@(negedge clk);
		col_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_settle(input logic [15:0] ticks);
		drain();
		@(negedge clk);
		settle_we   <= 1'b1;
		settle_data <= ticks;
		sb.settle = ticks;
		@(negedge clk);
		settle_we <= 1'b0;
	endtask

	// Mimic a keypad: keys held for a while, columns follow the scanned row, some noise
	task automatic run_random(input int count);
		logic [1:0] r;
		logic [3:0] cols;
		repeat (count) begin
			if ($urandom_range(99) < 6) begin
				case ($urandom_range(9))
					0, 1:    keys_held = '0;
					2, 3, 4, 5: keys_held = ONE_KEY << $urandom_range(15);
					6, 7, 8: keys_held = 16'($urandom);
					default: keys_held = ALL_KEYS;
				endcase
			end
			if (sb.phase == kps_pkg::PH_FIRST || sb.phase == kps_pkg::PH_SECOND)
				r = sb.row;
			else
				r = 2'($urandom_range(3));
			if ($urandom_range(99) < 8)
				cols = 4'($urandom_range(15));
			else
				cols = ALL_OPEN ^ keys_held[4 * r +: 4];
			send_columns(cols);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		settle_we            = 1'b0;
		settle_data          = '0;
		col_bus.valid        = 1'b0;
		col_bus.column_lines = '0;
		hold_req             = 0;
		keys_held            = '0;
		send_idle_pct        = 28;
		stall_pct            = 88;
		sb                   = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// One full round at the reset settle time, so the directed rounds start
		// at the first scan; then shortest settle for those rounds
		run_random(48);
		write_settle(16'd0);
		foreach (DIRECTED[i])
			send_columns(DIRECTED[i]);

		run_random(SEG_ITEMS);
		write_settle(16'd1);
		run_random(SEG_ITEMS);
		write_settle(16'd20);
		run_random(SEG_ITEMS);
		write_settle(16'd5);
		run_random(SEG_ITEMS);

		// Swap the idling sides; pause the sender once mid-run
		send_idle_pct = 88;
		stall_pct     = 28;
		write_settle(16'd3);
		run_random(SEG_ITEMS / 2);
		drain();
		run_random(SEG_ITEMS / 2);
		write_settle(16'd0);
		run_random(SEG_ITEMS);
		write_settle(16'd12);
		run_random(SEG_ITEMS);

		// Full rate, with one long result hold-off to back the block up
		send_idle_pct = 0;
		stall_pct     = 0;
		write_settle(16'd2);
		hold_req = 1;
		run_random(40);
		run_random(SEG_ITEMS);
		write_settle(16'($urandom_range(1, 15)));
		run_random(SEG_ITEMS);
		write_settle(16'd1);
		run_random(SEG_ITEMS);

		// Longest settle last, since its wait outlasts the rest of the run
		write_settle(ALL_KEYS);
		run_random(60);

		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
